### design/xtn_pkg.sv
`timescale 1ns / 1ps

package xtn_pkg;

    localparam int SYM_W    = 21;
    localparam int CNT_W    = 32;
    localparam int NEST_W   = 5;

    localparam logic [SYM_W-1:0] CH_LT    = 21'h00003C;
    localparam logic [SYM_W-1:0] CH_GT    = 21'h00003E;
    localparam logic [SYM_W-1:0] CH_SLASH = 21'h00002F;
    localparam logic [SYM_W-1:0] CH_QUEST = 21'h00003F;
    localparam logic [SYM_W-1:0] CH_BANG  = 21'h000021;
    localparam logic [SYM_W-1:0] CH_NL    = 21'h00000A;
    localparam logic [SYM_W-1:0] CH_TAB   = 21'h000009;
    localparam logic [SYM_W-1:0] CH_CR    = 21'h00000D;
    localparam logic [SYM_W-1:0] CH_SPACE = 21'h000020;

    localparam logic [CNT_W-1:0] CNT_MAX  = 32'hFFFF_FFFF;
    localparam logic [CNT_W-1:0] CNT_INIT = 32'd1;

    typedef enum logic [2:0] {
        EVT_NAME_CHAR = 3'd0,
        EVT_TAG_OPEN  = 3'd1,
        EVT_TAG_CLOSE = 3'd2,
        EVT_CONTENT   = 3'd3,
        EVT_DONE      = 3'd4,
        EVT_ERROR     = 3'd5
    } evt_kind_t;

    typedef enum logic [2:0] {
        ERR_LT_IN_NAME     = 3'd0,
        ERR_CLOSE_MISMATCH = 3'd1,
        ERR_NOT_XML        = 3'd2,
        ERR_UNCLOSED       = 3'd3,
        ERR_NAME_LONG      = 3'd4,
        ERR_TOO_DEEP       = 3'd5
    } err_code_t;

    typedef struct packed {
        logic [CNT_W-1:0]  symbol_number;
        logic [CNT_W-1:0]  line_number;
        err_code_t         error_code;
        logic [NEST_W-1:0] nest_depth;
        logic [SYM_W-1:0]  event_char;
        evt_kind_t         event_kind;
    } evt_t;

endpackage

### design/xtn_stack_mem.sv
`timescale 1ns / 1ps

module xtn_stack_mem #(
    parameter int ADDR_W = 4,
    parameter int DATA_W = 6
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // A write to the entry being fetched is forwarded so the read never sees stale data.
    always_ff @(posedge aclk) begin
        if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_reg <= wr_data;
        end else begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/xtn_ctrl.sv
`timescale 1ns / 1ps

module xtn_ctrl
    import xtn_pkg::*;
#(
    parameter int MAX_DEPTH    = 16,
    parameter int MAX_NAME_LEN = 32,
    parameter int DW = $clog2(MAX_DEPTH + 1),
    parameter int RW = $clog2(MAX_DEPTH),
    parameter int NW = $clog2(MAX_NAME_LEN + 1),
    parameter int CW = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  logic [SYM_W-1:0] symbol,
    input  logic             is_end,
    input  logic [SYM_W-1:0] top_char,
    input  logic [NW-1:0]    top_len,
    output logic             evt_valid,
    output evt_t             evt,
    output logic             name_wr_en,
    output logic [RW+CW-1:0] name_wr_addr,
    output logic [SYM_W-1:0] name_wr_data,
    output logic [RW+CW-1:0] name_rd_addr,
    output logic             len_wr_en,
    output logic [RW-1:0]    len_wr_addr,
    output logic [NW-1:0]    len_wr_data,
    output logic [RW-1:0]    len_rd_addr
);

    logic             in_open_name_reg,   in_open_name_next;
    logic             in_close_name_reg,  in_close_name_next;
    logic             name_saw_space_reg, name_saw_space_next;
    logic             in_content_reg,     in_content_next;
    logic             info_tag_reg,       info_tag_next;
    logic             name_mismatch_reg,  name_mismatch_next;
    logic             halted_reg,         halted_next;
    logic [NW-1:0]    name_length_reg,    name_length_next;
    logic [DW-1:0]    open_count_reg,     open_count_next;
    logic [CNT_W-1:0] line_count_reg,     line_count_next;
    logic [CNT_W-1:0] symbol_count_reg,   symbol_count_next;

    function automatic logic is_ws(input logic [SYM_W-1:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_open_name_reg   <= 1'b0;
            in_close_name_reg  <= 1'b0;
            name_saw_space_reg <= 1'b0;
            in_content_reg     <= 1'b0;
            info_tag_reg       <= 1'b0;
            name_mismatch_reg  <= 1'b0;
            halted_reg         <= 1'b0;
            name_length_reg    <= '0;
            open_count_reg     <= '0;
            line_count_reg     <= CNT_INIT;
            symbol_count_reg   <= CNT_INIT;
        end else begin
            in_open_name_reg   <= in_open_name_next;
            in_close_name_reg  <= in_close_name_next;
            name_saw_space_reg <= name_saw_space_next;
            in_content_reg     <= in_content_next;
            info_tag_reg       <= info_tag_next;
            name_mismatch_reg  <= name_mismatch_next;
            halted_reg         <= halted_next;
            name_length_reg    <= name_length_next;
            open_count_reg     <= open_count_next;
            line_count_reg     <= line_count_next;
            symbol_count_reg   <= symbol_count_next;
        end
    end

    always_comb begin
        logic           in_name;
        logic           fail;
        logic           count_upd;
        err_code_t      fail_code;
        logic [DW-1:0]  top_row;
        logic [DW+NEST_W-1:0] nest_ext;

        in_open_name_next   = in_open_name_reg;
        in_close_name_next  = in_close_name_reg;
        name_saw_space_next = name_saw_space_reg;
        in_content_next     = in_content_reg;
        info_tag_next       = info_tag_reg;
        name_mismatch_next  = name_mismatch_reg;
        halted_next         = halted_reg;
        name_length_next    = name_length_reg;
        open_count_next     = open_count_reg;
        line_count_next     = line_count_reg;
        symbol_count_next   = symbol_count_reg;

        in_name   = in_open_name_reg || in_close_name_reg;
        fail      = 1'b0;
        count_upd = 1'b0;
        fail_code = ERR_LT_IN_NAME;

        evt_valid = 1'b0;
        evt       = '0;

        name_wr_en   = 1'b0;
        name_wr_addr = {open_count_reg[RW-1:0], name_length_reg[CW-1:0]};
        name_wr_data = symbol;
        len_wr_en    = 1'b0;
        len_wr_addr  = open_count_reg[RW-1:0];
        len_wr_data  = name_length_reg;

        if (accept && !halted_reg) begin
            if (is_end) begin
                halted_next = 1'b1;
                evt_valid   = 1'b1;
                if (open_count_reg == '0) begin
                    evt.event_kind = EVT_DONE;
                end else begin
                    fail      = 1'b1;
                    fail_code = ERR_UNCLOSED;
                end
            end else begin
                count_upd = 1'b1;
                if ((symbol == CH_LT) && in_name) begin
                    fail      = 1'b1;
                    fail_code = ERR_LT_IN_NAME;
                end else if (is_ws(symbol) && in_name) begin
                    name_saw_space_next = 1'b1;
                end else if (symbol == CH_LT) begin
                    in_open_name_next  = 1'b1;
                    name_length_next   = '0;
                    info_tag_next      = 1'b0;
                    name_mismatch_next = 1'b0;
                end else if ((symbol == CH_SLASH) && in_open_name_reg) begin
                    in_open_name_next  = 1'b0;
                    in_close_name_next = 1'b1;
                end else if ((symbol == CH_GT) && in_open_name_reg) begin
                    in_open_name_next   = 1'b0;
                    name_saw_space_next = 1'b0;
                    in_content_next     = 1'b1;
                    name_length_next    = '0;
                    info_tag_next       = 1'b0;
                    name_mismatch_next  = 1'b0;
                    if ((name_length_reg == '0) || info_tag_reg) begin
                        // Declarations, comments and empty tags open nothing.
                        in_content_next = 1'b0;
                    end else if (open_count_reg >= DW'(MAX_DEPTH)) begin
                        fail      = 1'b1;
                        fail_code = ERR_TOO_DEEP;
                    end else begin
                        len_wr_en       = 1'b1;
                        open_count_next = open_count_reg + 1'b1;
                        evt_valid       = 1'b1;
                        evt.event_kind  = EVT_TAG_OPEN;
                    end
                end else if ((symbol == CH_GT) && in_close_name_reg) begin
                    in_content_next    = 1'b0;
                    in_open_name_next  = 1'b0;
                    in_close_name_next = 1'b0;
                    if ((open_count_reg == '0) || name_mismatch_reg || name_saw_space_reg ||
                        (name_length_reg != top_len)) begin
                        fail      = 1'b1;
                        fail_code = ERR_CLOSE_MISMATCH;
                    end else begin
                        open_count_next    = open_count_reg - 1'b1;
                        name_length_next   = '0;
                        info_tag_next      = 1'b0;
                        name_mismatch_next = 1'b0;
                        evt_valid          = 1'b1;
                        evt.event_kind     = EVT_TAG_CLOSE;
                    end
                end else if (in_name && !name_saw_space_reg) begin
                    if (name_length_reg >= NW'(MAX_NAME_LEN)) begin
                        fail      = 1'b1;
                        fail_code = ERR_NAME_LONG;
                    end else begin
                        if (name_length_reg == '0) begin
                            info_tag_next = (symbol == CH_QUEST) || (symbol == CH_BANG);
                        end
                        // The top entry was fetched in the previous cycle, so the compare
                        // keeps pace with the incoming characters.
                        if ((open_count_reg == '0) || (name_length_reg >= top_len) ||
                            (top_char != symbol)) begin
                            name_mismatch_next = 1'b1;
                        end
                        if (in_open_name_reg && (open_count_reg < DW'(MAX_DEPTH))) begin
                            name_wr_en = 1'b1;
                        end
                        name_length_next = name_length_reg + 1'b1;
                        evt_valid        = 1'b1;
                        evt.event_kind   = EVT_NAME_CHAR;
                        evt.event_char   = symbol;
                    end
                end else if (in_name) begin
                    // Attributes after a space in a tag are skipped.
                end else if (in_content_reg) begin
                    evt_valid      = 1'b1;
                    evt.event_kind = EVT_CONTENT;
                    evt.event_char = symbol;
                end else if (is_ws(symbol)) begin
                    // Whitespace between tags is ignored.
                end else begin
                    fail      = 1'b1;
                    fail_code = ERR_NOT_XML;
                end
            end

            if (fail) begin
                halted_next       = 1'b1;
                evt_valid         = 1'b1;
                evt.event_kind    = EVT_ERROR;
                evt.event_char    = '0;
                evt.error_code    = fail_code;
                evt.line_number   = line_count_reg;
                evt.symbol_number = symbol_count_reg;
                name_wr_en        = 1'b0;
                len_wr_en         = 1'b0;
                open_count_next   = open_count_reg;
            end else if (count_upd) begin
                if ((symbol == CH_NL) && (line_count_reg != CNT_MAX)) begin
                    line_count_next = line_count_reg + 1'b1;
                end
                if (symbol_count_reg != CNT_MAX) begin
                    symbol_count_next = symbol_count_reg + 1'b1;
                end
            end
        end

        nest_ext       = {{NEST_W{1'b0}}, open_count_next};
        evt.nest_depth = nest_ext[NEST_W-1:0];

        // Fetch the entries the next item will compare against.
        top_row      = open_count_next - 1'b1;
        name_rd_addr = {top_row[RW-1:0], name_length_next[CW-1:0]};
        len_rd_addr  = top_row[RW-1:0];
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        open_count_reg <= DW'(MAX_DEPTH))
        else $error("open tag count exceeds the stack depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        name_length_reg <= NW'(MAX_NAME_LEN))
        else $error("name length exceeds the maximum");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !(in_open_name_reg && in_close_name_reg))
        else $error("opening and closing name active together");

    assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |-> !evt_valid)
        else $error("event produced after halt");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (evt_valid && (evt.event_kind == EVT_TAG_OPEN)) |=>
            (open_count_reg == $past(open_count_reg) + 1'b1))
        else $error("tag open did not push the stack");

endmodule

### design/xml_tag_nesting_checker.sv
`timescale 1ns / 1ps
// Channel  Direction  tdata                                  tuser
// s_       in         [20:0] symbol                          [0] is_end
// m_       out        [20:0] event_char, [25:21] nest_depth,  [2:0] event_kind
//                     [28:26] error_code, [60:29] line_number,
//                     [92:61] symbol_number
//
// One character is taken per cycle while s_tready is high; its event sits in the output
// register in the cycle after the request is accepted.
// The top-of-stack name character and length are fetched from the stack memories in the
// cycle before they are compared, so no character has to wait for a read.
// Reset clears the control state at once; the stack memories need no clearing pass.
// The input is held off only while an event waits in the output register and m_tready is low.
module xml_tag_nesting_checker
    import xtn_pkg::*;
#(
    parameter int MAX_DEPTH    = 16,
    parameter int MAX_NAME_LEN = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [20:0] symbol
    input  logic        s_tuser,   // [0] is_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // event_char, nest_depth, error_code, line, symbol
    output logic [2:0]  m_tuser    // [2:0] event_kind
);

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int RW = $clog2(MAX_DEPTH);
    localparam int NW = $clog2(MAX_NAME_LEN + 1);
    localparam int CW = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1;

    logic             accept;
    logic             evt_valid;
    evt_t             evt;
    logic             name_wr_en;
    logic [RW+CW-1:0] name_wr_addr;
    logic [SYM_W-1:0] name_wr_data;
    logic [RW+CW-1:0] name_rd_addr;
    logic [SYM_W-1:0] top_char;
    logic             len_wr_en;
    logic [RW-1:0]    len_wr_addr;
    logic [NW-1:0]    len_wr_data;
    logic [RW-1:0]    len_rd_addr;
    logic [NW-1:0]    top_len;

    logic             m_valid_reg, m_valid_next;
    evt_t             m_evt_reg;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    xtn_ctrl #(
        .MAX_DEPTH    (MAX_DEPTH),
        .MAX_NAME_LEN (MAX_NAME_LEN),
        .DW           (DW),
        .RW           (RW),
        .NW           (NW),
        .CW           (CW)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .symbol       (s_tdata[SYM_W-1:0]),
        .is_end       (s_tuser),
        .top_char     (top_char),
        .top_len      (top_len),
        .evt_valid    (evt_valid),
        .evt          (evt),
        .name_wr_en   (name_wr_en),
        .name_wr_addr (name_wr_addr),
        .name_wr_data (name_wr_data),
        .name_rd_addr (name_rd_addr),
        .len_wr_en    (len_wr_en),
        .len_wr_addr  (len_wr_addr),
        .len_wr_data  (len_wr_data),
        .len_rd_addr  (len_rd_addr)
    );

    xtn_stack_mem #(
        .ADDR_W (RW + CW),
        .DATA_W (SYM_W)
    ) u_name_mem (
        .aclk    (aclk),
        .wr_en   (name_wr_en),
        .wr_addr (name_wr_addr),
        .wr_data (name_wr_data),
        .rd_addr (name_rd_addr),
        .rd_data (top_char)
    );

    xtn_stack_mem #(
        .ADDR_W (RW),
        .DATA_W (NW)
    ) u_len_mem (
        .aclk    (aclk),
        .wr_en   (len_wr_en),
        .wr_addr (len_wr_addr),
        .wr_data (len_wr_data),
        .rd_addr (len_rd_addr),
        .rd_data (top_len)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (evt_valid) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (evt_valid) begin
            m_evt_reg <= evt;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_evt_reg.event_kind;
    assign m_tdata  = {3'b000,
                       m_evt_reg.symbol_number,
                       m_evt_reg.line_number,
                       m_evt_reg.error_code,
                       m_evt_reg.nest_depth,
                       m_evt_reg.event_char};

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top
    import xtn_pkg::*;
();

    localparam int MAX_DEPTH      = 16;
    localparam int MAX_NAME_LEN   = 32;
    localparam int DIRECTED_ITEMS = 24;
    localparam int RANDOM_ITEMS   = 500;
    localparam int LONG_STALL     = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int REPORT_LIMIT   = 10;
    localparam logic [SYM_W-1:0] SYM_ALL_ONES = '1;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic [2:0]  m_tuser;

    // Tracks tag nesting and predicts the event stream of the checker.
    class nesting_scoreboard;
        bit               open_name, close_name, name_has_space, text_mode;
        bit               info_name, name_differs, stopped;
        int unsigned      name_len, depth;
        logic [CNT_W-1:0] line_no, sym_no;
        logic [SYM_W-1:0] stored_chars [MAX_DEPTH][MAX_NAME_LEN];
        int unsigned      stored_len [MAX_DEPTH];
        evt_t             awaited[$];
        int unsigned      mismatches;

        function new();
            open_name      = 1'b0;
            close_name     = 1'b0;
            name_has_space = 1'b0;
            text_mode      = 1'b0;
            info_name      = 1'b0;
            name_differs   = 1'b0;
            stopped        = 1'b0;
            name_len       = 0;
            depth          = 0;
            line_no        = CNT_INIT;
            sym_no         = CNT_INIT;
            mismatches     = 0;
        endfunction

        static function bit is_blank(logic [SYM_W-1:0] c);
            return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void post_event(evt_kind_t kind, logic [SYM_W-1:0] ch, err_code_t code,
                                 bit is_err);
            evt_t e;
            e.event_kind    = kind;
            e.event_char    = ch;
            e.nest_depth    = NEST_W'(depth);
            // Non-error events carry an all-zero code and position.
            e.error_code    = is_err ? code : ERR_LT_IN_NAME;
            e.line_number   = is_err ? line_no : '0;
            e.symbol_number = is_err ? sym_no : '0;
            awaited.insert(awaited.size(), e);
        endfunction

        function void halt_with(err_code_t code);
            stopped = 1'b1;
            post_event(EVT_ERROR, '0, code, 1'b1);
        endfunction

        function void note_request(logic [SYM_W-1:0] c, logic last);
            bit in_name;
            in_name = open_name || close_name;
            if (stopped)
                return;
            if (last) begin
                stopped = 1'b1;
                if (depth == 0)
                    post_event(EVT_DONE, '0, ERR_LT_IN_NAME, 1'b0);
                else
                    post_event(EVT_ERROR, '0, ERR_UNCLOSED, 1'b1);
                return;
            end

            if (c == CH_LT && in_name) begin
                halt_with(ERR_LT_IN_NAME);
                return;
            end else if (is_blank(c) && in_name) begin
                name_has_space = 1'b1;
            end else if (c == CH_LT) begin
                open_name    = 1'b1;
                name_len     = 0;
                info_name    = 1'b0;
                name_differs = 1'b0;
            end else if (c == CH_SLASH && open_name) begin
                open_name  = 1'b0;
                close_name = 1'b1;
            end else if (c == CH_GT && open_name) begin
                open_name      = 1'b0;
                name_has_space = 1'b0;
                text_mode      = 1'b1;
                if (name_len == 0 || info_name) begin
                    text_mode = 1'b0;
                end else if (depth >= MAX_DEPTH) begin
                    halt_with(ERR_TOO_DEEP);
                    return;
                end else begin
                    stored_len[depth] = name_len;
                    depth++;
                    post_event(EVT_TAG_OPEN, '0, ERR_LT_IN_NAME, 1'b0);
                end
                name_len     = 0;
                info_name    = 1'b0;
                name_differs = 1'b0;
            end else if (c == CH_GT && close_name) begin
                text_mode  = 1'b0;
                open_name  = 1'b0;
                close_name = 1'b0;
                if (depth == 0 || name_differs || name_has_space ||
                    name_len != stored_len[depth-1]) begin
                    halt_with(ERR_CLOSE_MISMATCH);
                    return;
                end
                depth--;
                name_len     = 0;
                info_name    = 1'b0;
                name_differs = 1'b0;
                post_event(EVT_TAG_CLOSE, '0, ERR_LT_IN_NAME, 1'b0);
            end else if (in_name && !name_has_space) begin
                if (name_len >= MAX_NAME_LEN) begin
                    halt_with(ERR_NAME_LONG);
                    return;
                end
                if (name_len == 0)
                    info_name = (c == CH_QUEST || c == CH_BANG);
                // Every name character is compared against the innermost open tag.
                if (depth == 0)
                    name_differs = 1'b1;
                else if (name_len >= stored_len[depth-1] ||
                         stored_chars[depth-1][name_len] != c)
                    name_differs = 1'b1;
                if (open_name && depth < MAX_DEPTH)
                    stored_chars[depth][name_len] = c;
                name_len++;
                post_event(EVT_NAME_CHAR, c, ERR_LT_IN_NAME, 1'b0);
            end else if (in_name) begin
                // Attribute text after a blank in a tag is dropped.
            end else if (text_mode) begin
                post_event(EVT_CONTENT, c, ERR_LT_IN_NAME, 1'b0);
            end else if (!is_blank(c)) begin
                halt_with(ERR_NOT_XML);
                return;
            end

            if (c == CH_NL && line_no != CNT_MAX)
                line_no++;
            if (sym_no != CNT_MAX)
                sym_no++;
        endfunction

        function void check_event(logic [95:0] data, logic [2:0] kind);
            evt_t seen, want;
            seen.event_kind    = evt_kind_t'(kind);
            seen.event_char    = data[20:0];
            seen.nest_depth    = data[25:21];
            seen.error_code    = err_code_t'(data[28:26]);
            seen.line_number   = data[60:29];
            seen.symbol_number = data[92:61];
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected event kind %0d char %h depth %0d code %0d",
                             $realtime, seen.event_kind, seen.event_char, seen.nest_depth,
                             seen.error_code);
                return;
            end
            want = awaited.pop_front();
            if (seen.event_kind !== want.event_kind || seen.event_char !== want.event_char ||
                seen.nest_depth !== want.nest_depth || seen.error_code !== want.error_code ||
                seen.line_number !== want.line_number ||
                seen.symbol_number !== want.symbol_number) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("%0t: event mismatch", $realtime);
                    $display("  expected kind %0d char %h depth %0d code %0d line %0d sym %0d",
                             want.event_kind, want.event_char, want.nest_depth,
                             want.error_code, want.line_number, want.symbol_number);
                    $display("  actual   kind %0d char %h depth %0d code %0d line %0d sym %0d",
                             seen.event_kind, seen.event_char, seen.nest_depth,
                             seen.error_code, seen.line_number, seen.symbol_number);
                end
            end
        endfunction
    endclass

    nesting_scoreboard scoreboard = new();

    // Names of the tags this stimulus has opened, innermost at open_depth - 1.
    logic [SYM_W-1:0] tag_chars [MAX_DEPTH][MAX_NAME_LEN];
    int               tag_len [MAX_DEPTH];
    int               open_depth        = 0;
    bit               text_ok           = 1'b0;
    int unsigned      requests_sent     = 0;
    int unsigned      sender_idle_pct   = 36;
    int unsigned      receiver_idle_pct = 59;
    bit               long_stall_req    = 1'b0;
    int unsigned      cycle_count       = 0;

    xml_tag_nesting_checker #(
        .MAX_DEPTH    (MAX_DEPTH),
        .MAX_NAME_LEN (MAX_NAME_LEN)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // The receiver also runs one long hold-off so that the input side backs up.
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (long_stall_req) begin
                long_stall_req = 1'b0;
                stall_left     = LONG_STALL;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= receiver_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            scoreboard.check_event(m_tdata, m_tuser);
    end

    task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic last = 1'b0);
        if ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, sym};
        s_tuser  <= last;
        do @(posedge aclk); while (!s_tready);
        scoreboard.note_request(sym, last);
        requests_sent++;
    endtask

    function automatic logic [SYM_W-1:0] pick_any();
        case ($urandom_range(3))
            0, 1:    return SYM_W'($urandom_range(8'h7E, 8'h21));
            2:       return SYM_W'($urandom);
            default: return SYM_W'($urandom_range(21'h10FFFF));
        endcase
    endfunction

    function automatic logic [SYM_W-1:0] pick_blank();
        if ($urandom_range(1) == 0)
            return CH_SPACE;
        return SYM_W'($urandom_range(CH_CR, CH_TAB));
    endfunction

    function automatic logic [SYM_W-1:0] pick_name_char(input bit first);
        logic [SYM_W-1:0] c;
        do c = pick_any();
        while (c == CH_LT || c == CH_GT || c == CH_SLASH || nesting_scoreboard::is_blank(c) ||
               (first && (c == CH_QUEST || c == CH_BANG)));
        return c;
    endfunction

    function automatic logic [SYM_W-1:0] pick_attr_char();
        logic [SYM_W-1:0] c;
        do c = pick_any(); while (c == CH_LT || c == CH_GT || c == CH_SLASH);
        return c;
    endfunction

    function automatic int pick_name_len();
        case ($urandom_range(15))
            0:       return MAX_NAME_LEN;
            1:       return $urandom_range(MAX_NAME_LEN, 1);
            default: return $urandom_range(6, 1);
        endcase
    endfunction

    task automatic send_ascii(input string text);
        for (int i = 0; i < text.len(); i++)
            send_symbol(SYM_W'(text[i]));
    endtask

    task automatic send_blanks();
        repeat ($urandom_range(3, 1)) send_symbol(pick_blank());
    endtask

    task automatic open_tag(input int len);
        logic [SYM_W-1:0] c;
        send_symbol(CH_LT);
        for (int i = 0; i < len; i++) begin
            c = pick_name_char(i == 0);
            if (open_depth < MAX_DEPTH)
                tag_chars[open_depth][i] = c;
            send_symbol(c);
        end
        if ($urandom_range(3) == 0) begin
            send_symbol(pick_blank());
            repeat ($urandom_range(4)) send_symbol(pick_attr_char());
        end
        send_symbol(CH_GT);
        if (open_depth < MAX_DEPTH)
            tag_len[open_depth] = len;
        open_depth++;
        text_ok = 1'b1;
    endtask

    // A slash typed after some name characters turns the tag into a closing one.
    task automatic close_tag();
        int top, cut;
        top = open_depth - 1;
        cut = ($urandom_range(3) == 0) ? $urandom_range(tag_len[top]) : 0;
        send_symbol(CH_LT);
        for (int i = 0; i < cut; i++)
            send_symbol(tag_chars[top][i]);
        send_symbol(CH_SLASH);
        for (int i = cut; i < tag_len[top]; i++)
            send_symbol(tag_chars[top][i]);
        send_symbol(CH_GT);
        open_depth--;
        text_ok = 1'b0;
    endtask

    task automatic info_tag();
        send_symbol(CH_LT);
        send_symbol($urandom_range(1) ? CH_QUEST : CH_BANG);
        repeat ($urandom_range(6)) send_symbol(pick_attr_char());
        send_symbol(CH_GT);
        text_ok = 1'b0;
    endtask

    task automatic empty_tag();
        send_symbol(CH_LT);
        send_symbol(CH_GT);
        text_ok = 1'b0;
    endtask

    task automatic random_step();
        int pick;
        logic [SYM_W-1:0] c;
        pick = $urandom_range(99);
        if (open_depth == 0) begin
            if (pick < 55)
                open_tag(pick_name_len());
            else if (pick < 70)
                info_tag();
            else if (pick < 78)
                empty_tag();
            else
                send_blanks();
        end else if (pick < 28 && open_depth < MAX_DEPTH) begin
            open_tag(pick_name_len());
        end else if (pick < 53) begin
            close_tag();
        end else if (pick < 82) begin
            if (text_ok) begin
                repeat ($urandom_range(8, 1)) begin
                    if ($urandom_range(4) == 0)
                        c = pick_blank();
                    else
                        do c = pick_any(); while (c == CH_LT);
                    send_symbol(c);
                end
            end else begin
                send_blanks();
            end
        end else if (pick < 89) begin
            info_tag();
        end else if (pick < 93) begin
            empty_tag();
        end else begin
            send_blanks();
        end
    endtask

    // Ends the document either cleanly or with one of the errors, which halts the block.
    task automatic finish_document();
        logic [SYM_W-1:0] c;
        int top;
        case ($urandom_range(8))
            0: begin
                while (open_depth > 0) close_tag();
                send_symbol(pick_any(), 1'b1);
            end
            1: begin
                if (open_depth == 0)
                    open_tag(1);
                send_symbol(pick_any(), 1'b1);
            end
            2: begin
                send_symbol(CH_LT);
                send_symbol(pick_name_char(1'b1));
                send_symbol(CH_LT);
            end
            3: begin
                if (open_depth == 0)
                    open_tag(2);
                top = open_depth - 1;
                send_symbol(CH_LT);
                send_symbol(CH_SLASH);
                for (int i = 0; i < tag_len[top] - 1; i++)
                    send_symbol(tag_chars[top][i]);
                do c = pick_name_char(1'b0); while (c == tag_chars[top][tag_len[top]-1]);
                send_symbol(c);
                send_symbol(CH_GT);
            end
            4: begin
                while (open_depth > 0) close_tag();
                send_symbol(CH_LT);
                send_symbol(CH_SLASH);
                send_symbol(pick_name_char(1'b1));
                send_symbol(CH_GT);
            end
            5: begin
                while (open_depth > 0) close_tag();
                do c = pick_any(); while (c == CH_LT || nesting_scoreboard::is_blank(c));
                send_symbol(c);
            end
            6: begin
                send_symbol(CH_LT);
                for (int i = 0; i <= MAX_NAME_LEN; i++)
                    send_symbol(pick_name_char(i == 0));
            end
            7: begin
                while (open_depth <= MAX_DEPTH) open_tag($urandom_range(3, 1));
            end
            default: begin
                if (open_depth == 0)
                    open_tag(1);
                top = open_depth - 1;
                send_symbol(CH_LT);
                send_symbol(CH_SLASH);
                for (int i = 0; i < tag_len[top]; i++)
                    send_symbol(tag_chars[top][i]);
                send_symbol(pick_blank());
                send_symbol(CH_GT);
            end
        endcase
    endtask

    initial begin : stimulus
        bit stall_done;
        stall_done = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Blanks between tags, an info tag and an empty tag push nothing.
        send_symbol(CH_SPACE);
        send_symbol(CH_TAB);
        send_symbol(CH_CR);
        send_ascii("<?x>");
        empty_tag();
        // The all-ones 21-bit symbol as a name, with attributes after a blank.
        send_symbol(CH_LT);
        send_symbol(SYM_ALL_ONES);
        send_ascii(" q=1>");
        send_symbol('0);
        send_symbol(SYM_ALL_ONES);
        send_symbol(21'h110000);
        send_symbol(CH_NL);
        // Closed again through a slash typed after the name.
        send_symbol(CH_LT);
        send_symbol(SYM_ALL_ONES);
        send_symbol(CH_SLASH);
        send_symbol(CH_GT);

        while (requests_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
            if (requests_sent >= 400) begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end else if (requests_sent >= 200) begin
                sender_idle_pct   = 59;
                receiver_idle_pct = 36;
            end
            if (!stall_done && requests_sent >= 120) begin
                long_stall_req = 1'b1;
                stall_done     = 1'b1;
            end
            random_step();
        end

        finish_document();
        // The block is halted now and must stay silent.
        repeat (6) send_symbol(pick_any(), 1'($urandom_range(1)));
        send_symbol(SYM_ALL_ONES, 1'b1);
        s_tvalid <= 1'b0;

        while (scoreboard.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (scoreboard.mismatches == 0 && scoreboard.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### sim.f
design/xtn_pkg.sv
design/xtn_stack_mem.sv
design/xtn_ctrl.sv
design/xml_tag_nesting_checker.sv
tb/sv/tb_top.sv
